@@ design/sil_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants for the sorted interval lookup unit.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int MAX_LINES  = 1024;
  localparam int COORD_W    = 32;
  localparam int FIRST_W    = 10;
  localparam int MCOUNT_W   = 11;
  localparam int IDX_W      = $clog2(MAX_LINES);
  localparam int CNT_W      = $clog2(MAX_LINES + 1);
  localparam int STK_DEPTH  = $clog2(MAX_LINES + 1);
  localparam int SP_W       = $clog2(STK_DEPTH + 1);
  localparam int STK_IDX_W  = $clog2(STK_DEPTH);

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_POINT  = 2'd2,
    KIND_RANGE  = 2'd3
  } kind_e_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DROP = 2'd2
  } status_e_t;

  typedef struct packed {
    kind_e_t              kind;
    logic [COORD_W-1:0]   line_low;
    logic [COORD_W-1:0]   line_high;
    logic [COORD_W-1:0]   query_y;
    logic [COORD_W-1:0]   range_low;
    logic [COORD_W-1:0]   range_high;
  } in_beat_t;

  typedef struct packed {
    status_e_t            status;
    logic [FIRST_W-1:0]   first_index;
    logic [MCOUNT_W-1:0]  match_count;
    logic [COORD_W-1:0]   content_height;
  } out_beat_t;

  typedef struct packed {
    logic                 start;
    logic                 point;
    logic [COORD_W-1:0]   bound_lo;
    logic [COORD_W-1:0]   bound_hi;
    logic [CNT_W-1:0]     n_entries;
  } search_req_t;

  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [IDX_W-1:0]     first;
    logic [CNT_W-1:0]     count;
  } search_rsp_t;

endpackage

@@ design/sil_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_mem
// Interval store: low and high Y per entry, one write and one registered read.
// ----------------------------------------------------------------------------
module sil_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [sil_pkg::IDX_W-1:0]  wr_addr,
  input  logic [sil_pkg::COORD_W-1:0] wr_low,
  input  logic [sil_pkg::COORD_W-1:0] wr_high,
  input  logic [sil_pkg::IDX_W-1:0]  rd_addr,
  output logic [sil_pkg::COORD_W-1:0] rd_low,
  output logic [sil_pkg::COORD_W-1:0] rd_high
);
  import sil_pkg::*;

  logic [COORD_W-1:0] low_mem  [MAX_LINES];
  logic [COORD_W-1:0] high_mem [MAX_LINES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      low_mem[wr_addr]  <= wr_low;
      high_mem[wr_addr] <= wr_high;
    end
  end

  always_ff @(posedge clk) begin
    rd_low  <= low_mem[rd_addr];
    rd_high <= high_mem[rd_addr];
  end

endmodule

@@ design/sil_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_search
// Tree search sequencer: one probe of the interval store per step, with a
// small frame stack for the pruned in-order walk of range queries.
// ----------------------------------------------------------------------------
module sil_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sil_pkg::search_req_t        req,
  output sil_pkg::search_rsp_t        rsp,
  output logic [sil_pkg::IDX_W-1:0]   rd_addr,
  input  logic [sil_pkg::COORD_W-1:0] rd_low,
  input  logic [sil_pkg::COORD_W-1:0] rd_high
);
  import sil_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_NODE = 3'b010,
    S_CMP  = 3'b100
  } srch_state_t;

  srch_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cur_lo_r, cur_lo_nxt;
  logic [CNT_W-1:0]   cur_hi_r, cur_hi_nxt;
  logic [IDX_W-1:0]   node_r, node_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   first_r, first_nxt;
  logic               point_r, point_nxt;
  logic [COORD_W-1:0] blo_r, blo_nxt;
  logic [COORD_W-1:0] bhi_r, bhi_nxt;
  logic               done_r, done_nxt;
  logic               found_r, found_nxt;

  logic [IDX_W-1:0]   stk_node_r [STK_DEPTH];
  logic [CNT_W-1:0]   stk_hi_r   [STK_DEPTH];
  logic               push;
  logic [SP_W-1:0]    sp_dec;
  logic [IDX_W-1:0]   top_node;
  logic [CNT_W-1:0]   top_hi;
  logic [CNT_W-1:0]   mid;
  logic               above;
  logic               below;

  assign mid      = cur_lo_r + ((cur_hi_r - cur_lo_r) >> 1);
  assign rd_addr  = mid[IDX_W-1:0];
  assign sp_dec   = sp_r - SP_W'(1);
  assign top_node = stk_node_r[sp_dec[STK_IDX_W-1:0]];
  assign top_hi   = stk_hi_r[sp_dec[STK_IDX_W-1:0]];
  assign above    = rd_low > bhi_r;
  assign below    = rd_high < blo_r;

  always_comb begin
    state_nxt  = state_r;
    cur_lo_nxt = cur_lo_r;
    cur_hi_nxt = cur_hi_r;
    node_nxt   = node_r;
    sp_nxt     = sp_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    point_nxt  = point_r;
    blo_nxt    = blo_r;
    bhi_nxt    = bhi_r;
    found_nxt  = found_r;
    done_nxt   = 1'b0;
    push       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          cur_lo_nxt = '0;
          cur_hi_nxt = req.n_entries;
          sp_nxt     = '0;
          cnt_nxt    = '0;
          first_nxt  = '0;
          found_nxt  = 1'b0;
          point_nxt  = req.point;
          blo_nxt    = req.bound_lo;
          bhi_nxt    = req.bound_hi;
          state_nxt  = S_NODE;
        end
      end
      S_NODE: begin
        if (cur_lo_r >= cur_hi_r) begin
          if (point_r || sp_r == '0) begin
            done_nxt  = 1'b1;
            found_nxt = !point_r && cnt_r != '0;
            state_nxt = S_IDLE;
          end else begin
            if (cnt_r == '0) begin
              first_nxt = top_node;
            end
            cnt_nxt    = cnt_r + CNT_W'(1);
            cur_lo_nxt = CNT_W'(top_node) + CNT_W'(1);
            cur_hi_nxt = top_hi;
            sp_nxt     = sp_dec;
          end
        end else begin
          node_nxt  = mid[IDX_W-1:0];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_NODE;
        if (point_r) begin
          if (!above && !below) begin
            found_nxt = 1'b1;
            first_nxt = node_r;
            cnt_nxt   = CNT_W'(1);
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (above) begin
            cur_hi_nxt = CNT_W'(node_r);
          end else begin
            cur_lo_nxt = CNT_W'(node_r) + CNT_W'(1);
          end
        end else begin
          if (below) begin
            cur_lo_nxt = CNT_W'(node_r) + CNT_W'(1);
          end else if (above) begin
            cur_hi_nxt = CNT_W'(node_r);
          end else begin
            push       = 1'b1;
            sp_nxt     = sp_r + SP_W'(1);
            cur_hi_nxt = CNT_W'(node_r);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_lo_r  <= cur_lo_nxt;
    cur_hi_r  <= cur_hi_nxt;
    node_r    <= node_nxt;
    cnt_r     <= cnt_nxt;
    first_r   <= first_nxt;
    point_r   <= point_nxt;
    blo_r     <= blo_nxt;
    bhi_r     <= bhi_nxt;
    found_r   <= found_nxt;
    if (push) begin
      stk_node_r[sp_r[STK_IDX_W-1:0]] <= node_r;
      stk_hi_r[sp_r[STK_IDX_W-1:0]]   <= cur_hi_r;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.found = found_r;
  assign rsp.first = first_r;
  assign rsp.count = cnt_r;

endmodule

@@ design/sorted_interval_lookup_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_lookup_unit
// Interval table with clear, append, point lookup and range query beats.
// ----------------------------------------------------------------------------
// Clear and append: the result goes from T_RESP into the output register.
// Point lookup: S_NODE and S_CMP for each tree probe (at most 11 probes).
// Range query: S_NODE and S_CMP per visited node, and an S_NODE pop per match.
// One item at a time; the next beat is taken while a result waits at out_.
// Reset empties the table and output; the store itself is not cleared.
module sorted_interval_lookup_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sil_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sil_pkg::out_beat_t  out_data
);
  import sil_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_SEARCH = 3'b010,
    T_RESP   = 3'b100
  } top_state_t;

  top_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   entry_cnt_r, entry_cnt_nxt;
  logic [COORD_W-1:0] last_high_r, last_high_nxt;
  status_e_t          pend_status_r, pend_status_nxt;
  logic [IDX_W-1:0]   pend_first_r, pend_first_nxt;
  logic [CNT_W-1:0]   pend_count_r, pend_count_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               full;
  logic               wr_en;
  logic               load;
  search_req_t        req;
  search_rsp_t        rsp;
  logic [IDX_W-1:0]   rd_addr;
  logic [COORD_W-1:0] rd_low;
  logic [COORD_W-1:0] rd_high;

  assign in_ready = state_r == T_IDLE;
  assign accept   = in_valid && in_ready;
  assign full     = entry_cnt_r == CNT_W'(MAX_LINES);
  assign load     = state_r == T_RESP && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    entry_cnt_nxt   = entry_cnt_r;
    last_high_nxt   = last_high_r;
    pend_status_nxt = pend_status_r;
    pend_first_nxt  = pend_first_r;
    pend_count_nxt  = pend_count_r;
    wr_en           = 1'b0;
    req.start       = 1'b0;
    req.point       = in_data.kind == KIND_POINT;
    req.bound_lo    = (in_data.kind == KIND_POINT) ? in_data.query_y : in_data.range_low;
    req.bound_hi    = (in_data.kind == KIND_POINT) ? in_data.query_y : in_data.range_high;
    req.n_entries   = entry_cnt_r;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          pend_status_nxt = ST_OK;
          pend_first_nxt  = '0;
          pend_count_nxt  = '0;
          state_nxt       = T_RESP;
          unique case (in_data.kind)
            KIND_CLEAR: begin
              entry_cnt_nxt = '0;
              last_high_nxt = '0;
            end
            KIND_APPEND: begin
              if (full) begin
                pend_status_nxt = ST_DROP;
              end else begin
                wr_en         = 1'b1;
                entry_cnt_nxt = entry_cnt_r + CNT_W'(1);
                last_high_nxt = in_data.line_high;
              end
            end
            KIND_POINT, KIND_RANGE: begin
              req.start = 1'b1;
              state_nxt = T_SEARCH;
            end
            default: state_nxt = T_RESP;
          endcase
        end
      end
      T_SEARCH: begin
        if (rsp.done) begin
          pend_status_nxt = rsp.found ? ST_OK : ST_MISS;
          pend_first_nxt  = rsp.found ? rsp.first : '0;
          pend_count_nxt  = rsp.found ? rsp.count : '0;
          state_nxt       = T_RESP;
        end
      end
      T_RESP: begin
        if (load) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = pend_status_r;
      out_data_nxt.first_index    = FIRST_W'(pend_first_r);
      out_data_nxt.match_count    = MCOUNT_W'(pend_count_r);
      out_data_nxt.content_height = last_high_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      entry_cnt_r <= '0;
      last_high_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      last_high_r <= last_high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_first_r  <= pend_first_nxt;
    pend_count_r  <= pend_count_nxt;
    out_data_r    <= out_data_nxt;
  end

  sil_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_cnt_r[IDX_W-1:0]),
    .wr_low  (in_data.line_low),
    .wr_high (in_data.line_high),
    .rd_addr (rd_addr),
    .rd_low  (rd_low),
    .rd_high (rd_high)
  );

  sil_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rsp     (rsp),
    .rd_addr (rd_addr),
    .rd_low  (rd_low),
    .rd_high (rd_high)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/sil_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_checker
// Port-level checks for the sorted interval lookup unit, bound to the top.
// ----------------------------------------------------------------------------
module sil_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input sil_pkg::in_beat_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sil_pkg::out_beat_t  out_data
);
  import sil_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.first_index == '0 && out_data.match_count == '0)
    else $error("miss or drop carries nonzero index or count");

endmodule

bind sorted_interval_lookup_unit sil_checker u_sil_checker (.*);
